[hw/rtl/nfcs_pkg.sv]
package nfcs_pkg;

    // Flash address width; request addresses are masked to this many bits.
    localparam int ADDR_BITS = 22;
    localparam int ADDR_W    = 22;
    localparam int PROT_W    = 23;
    localparam int CFG_IDX_W = 2;

    localparam logic [ADDR_W-1:0] ADDR_MASK =
        (ADDR_BITS >= ADDR_W) ? {ADDR_W{1'b1}}
                              : ADDR_W'((64'd1 << ADDR_BITS) - 64'd1);

    // Register indexes on the configuration channel
    localparam logic [CFG_IDX_W-1:0] REG_PROTECT_LOW  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_PROTECT_HIGH = 2'd1;
    localparam logic [PROT_W-1:0]    PROTECT_LOW_RST  = 23'h1A0000;
    localparam logic [PROT_W-1:0]    PROTECT_HIGH_RST = 23'h200000;

    // Request actions
    localparam logic [2:0] ACT_READ_ID      = 3'd0;
    localparam logic [2:0] ACT_CFI          = 3'd1;
    localparam logic [2:0] ACT_PROGRAM      = 3'd2;
    localparam logic [2:0] ACT_ERASE        = 3'd3;
    localparam logic [2:0] ACT_BYPASS_ENTER = 3'd4;
    localparam logic [2:0] ACT_BYPASS_PROG  = 3'd5;
    localparam logic [2:0] ACT_BYPASS_EXIT  = 3'd6;
    localparam logic [2:0] ACT_READ_RETURN  = 3'd7;

    // Lane selects for bypass program
    localparam logic [1:0] LANES_LOW  = 2'd1;
    localparam logic [1:0] LANES_HIGH = 2'd2;

    // Operation status
    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_FAIL    = 2'd1;
    localparam logic [1:0] ST_REFUSED = 2'd2;
    localparam logic [1:0] ST_MODE    = 2'd3;

    // Bus sequences the back end expands
    localparam int SEQ_W = 4;
    localparam logic [SEQ_W-1:0] SEQ_DONE      = 4'd0;
    localparam logic [SEQ_W-1:0] SEQ_READ_ID   = 4'd1;
    localparam logic [SEQ_W-1:0] SEQ_CFI       = 4'd2;
    localparam logic [SEQ_W-1:0] SEQ_PROGRAM   = 4'd3;
    localparam logic [SEQ_W-1:0] SEQ_ERASE     = 4'd4;
    localparam logic [SEQ_W-1:0] SEQ_BYP_ENTER = 4'd5;
    localparam logic [SEQ_W-1:0] SEQ_BYP_PROG  = 4'd6;
    localparam logic [SEQ_W-1:0] SEQ_BYP_EXIT  = 4'd7;
    localparam logic [SEQ_W-1:0] SEQ_READ      = 4'd8;
    localparam logic [SEQ_W-1:0] SEQ_RST_DONE  = 4'd9;

    // Command bus addresses and data
    localparam logic [ADDR_W-1:0] A_ZERO  = 22'h000000;
    localparam logic [ADDR_W-1:0] A_AAA   = 22'h000AAA;
    localparam logic [ADDR_W-1:0] A_554   = 22'h000554;
    localparam logic [ADDR_W-1:0] A_0AA   = 22'h0000AA;
    localparam logic [ADDR_W-1:0] A_ID0   = 22'h000002;
    localparam logic [ADDR_W-1:0] A_ID1   = 22'h00001C;
    localparam logic [ADDR_W-1:0] A_ID2   = 22'h00001E;
    localparam logic [15:0] D_AA    = 16'h00AA;
    localparam logic [15:0] D_55    = 16'h0055;
    localparam logic [15:0] D_90    = 16'h0090;
    localparam logic [15:0] D_F0    = 16'h00F0;
    localparam logic [15:0] D_98    = 16'h0098;
    localparam logic [15:0] D_A0    = 16'h00A0;
    localparam logic [15:0] D_80    = 16'h0080;
    localparam logic [15:0] D_20    = 16'h0020;
    localparam logic [15:0] D_30    = 16'h0030;
    localparam logic [15:0] D_00    = 16'h0000;

    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

    typedef struct packed {
        logic [2:0]        action;
        logic [ADDR_W-1:0] address;
        logic [15:0]       write_data;
        logic [1:0]        lanes;
        logic [15:0]       read_data;
    } request_t;

    typedef struct packed {
        logic              bus_write;
        logic              bus_read;
        logic [ADDR_W-1:0] bus_address;
        logic [15:0]       bus_data;
        logic              op_done;
        logic [1:0]        op_status;
        logic [23:0]       id_value;
        logic              last;
    } result_t;

    typedef struct packed {
        logic [SEQ_W-1:0]  seq;
        logic [ADDR_W-1:0] addr;
        logic [15:0]       data;
        logic [1:0]        status;
        logic [23:0]       id;
    } job_t;

    // Queue handshake between front and back
    typedef struct packed {
        logic valid;
        job_t job;
    } job_push_t;

    function automatic job_t make_job(logic [SEQ_W-1:0] seq, logic [ADDR_W-1:0] addr,
                                      logic [15:0] data, logic [1:0] status,
                                      logic [23:0] id);
        job_t j;
        j.seq    = seq;
        j.addr   = addr;
        j.data   = data;
        j.status = status;
        j.id     = id;
        return j;
    endfunction

    function automatic result_t wr_item(logic [ADDR_W-1:0] a, logic [15:0] d);
        result_t r;
        r = '0;
        r.bus_write   = 1'b1;
        r.bus_address = a;
        r.bus_data    = d;
        return r;
    endfunction

    function automatic result_t rd_item(logic [ADDR_W-1:0] a);
        result_t r;
        r = '0;
        r.bus_read    = 1'b1;
        r.bus_address = a;
        return r;
    endfunction

    function automatic result_t done_item(logic [1:0] st, logic [23:0] id);
        result_t r;
        r = '0;
        r.op_done   = 1'b1;
        r.op_status = st;
        r.id_value  = id;
        return r;
    endfunction

    function automatic logic [2:0] seq_last_step(logic [SEQ_W-1:0] seq);
        logic [2:0] n;
        unique case (seq)
            SEQ_READ_ID:   n = 3'd3;
            SEQ_CFI:       n = 3'd1;
            SEQ_PROGRAM:   n = 3'd4;
            SEQ_ERASE:     n = 3'd6;
            SEQ_BYP_ENTER: n = 3'd3;
            SEQ_BYP_PROG:  n = 3'd2;
            SEQ_BYP_EXIT:  n = 3'd2;
            SEQ_RST_DONE:  n = 3'd1;
            default:       n = 3'd0;
        endcase
        return n;
    endfunction

    function automatic logic [ADDR_W-1:0] sector_of(logic [ADDR_W-1:0] a);
        logic [ADDR_W-1:0] s;
        if (|a[ADDR_W-1:16])
            s = {a[ADDR_W-1:16], 16'h0000};
        else
            s = {a[ADDR_W-1:13], 13'h0000};
        return s;
    endfunction

    // One bus cycle or completion of a job, selected by step
    function automatic result_t gen_step(job_t j, logic [2:0] step);
        result_t r;
        r = '0;
        unique case (j.seq)
            SEQ_DONE:
                r = done_item(j.status, j.id);
            SEQ_READ_ID:
                unique case (step)
                    3'd0:    r = wr_item(A_AAA, D_AA);
                    3'd1:    r = wr_item(A_554, D_55);
                    3'd2:    r = wr_item(A_AAA, D_90);
                    default: r = rd_item(A_ID0);
                endcase
            SEQ_CFI:
                unique case (step)
                    3'd0:    r = wr_item(A_0AA, D_98);
                    default: r = rd_item(j.addr);
                endcase
            SEQ_PROGRAM:
                unique case (step)
                    3'd0:    r = wr_item(A_AAA, D_AA);
                    3'd1:    r = wr_item(A_554, D_55);
                    3'd2:    r = wr_item(A_AAA, D_A0);
                    3'd3:    r = wr_item(j.addr, j.data);
                    default: r = rd_item(j.addr);
                endcase
            SEQ_ERASE:
                unique case (step)
                    3'd0:    r = wr_item(A_AAA, D_AA);
                    3'd1:    r = wr_item(A_554, D_55);
                    3'd2:    r = wr_item(A_AAA, D_80);
                    3'd3:    r = wr_item(A_AAA, D_AA);
                    3'd4:    r = wr_item(A_554, D_55);
                    3'd5:    r = wr_item(sector_of(j.addr), D_30);
                    default: r = rd_item(j.addr);
                endcase
            SEQ_BYP_ENTER:
                unique case (step)
                    3'd0:    r = wr_item(A_AAA, D_AA);
                    3'd1:    r = wr_item(A_554, D_55);
                    3'd2:    r = wr_item(A_AAA, D_20);
                    default: r = done_item(ST_OK, 24'h000000);
                endcase
            SEQ_BYP_PROG:
                unique case (step)
                    3'd0:    r = wr_item(A_ZERO, D_A0);
                    3'd1:    r = wr_item(j.addr, j.data);
                    default: r = rd_item(j.addr);
                endcase
            SEQ_BYP_EXIT:
                unique case (step)
                    3'd0:    r = wr_item(A_ZERO, D_90);
                    3'd1:    r = wr_item(A_ZERO, D_00);
                    default: r = done_item(ST_OK, 24'h000000);
                endcase
            SEQ_READ:
                r = rd_item(j.addr);
            SEQ_RST_DONE:
                unique case (step)
                    3'd0:    r = wr_item(A_ZERO, D_F0);
                    default: r = done_item(j.status, j.id);
                endcase
            default:
                r = '0;
        endcase
        r.last = (step == seq_last_step(j.seq));
        return r;
    endfunction

endpackage

[hw/rtl/nfcs_front.sv]
module nfcs_front
    import nfcs_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 push,
    input  request_t             request,
    input  logic                 queue_full,
    input  logic                 cfg_valid,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [PROT_W-1:0]    cfg_data,
    output job_push_t            job_push
);

    localparam logic [2:0] PH_IDLE         = 3'd0;
    localparam logic [2:0] PH_ID_WAIT      = 3'd1;
    localparam logic [2:0] PH_CFI_WAIT     = 3'd2;
    localparam logic [2:0] PH_POLL_FIRST   = 3'd3;
    localparam logic [2:0] PH_POLL         = 3'd4;
    localparam logic [2:0] PH_POLL_CONFIRM = 3'd5;

    logic [PROT_W-1:0] prot_low_reg, prot_high_reg;
    logic [2:0]        phase_reg, phase_next;
    logic              bypass_reg, bypass_next;
    logic [ADDR_W-1:0] poll_addr_reg, poll_addr_next;
    logic              exp7_reg, exp7_next;
    logic              poll_prog_reg, poll_prog_next;
    logic [23:0]       id_acc_reg, id_acc_next;
    logic [1:0]        id_cnt_reg, id_cnt_next;

    logic              accept;
    logic [ADDR_W-1:0] addr, word_addr;
    logic [23:0]       acc_shift;
    logic [1:0]        cnt_inc;
    logic              poll_hit;
    logic              mode_bad;
    logic [15:0]       byp_word;
    logic [1:0]        confirm_st;

    function automatic logic in_window(logic [ADDR_W-1:0] a, logic [PROT_W-1:0] lo,
                                       logic [PROT_W-1:0] hi);
        return ({1'b0, a} >= lo) && ({1'b0, a} < hi);
    endfunction

    function automatic logic [ADDR_W-1:0] id_addr(logic [1:0] n);
        logic [ADDR_W-1:0] a;
        unique case (n)
            2'd1:    a = A_ID1;
            2'd2:    a = A_ID2;
            default: a = A_ID0;
        endcase
        return a;
    endfunction

    assign accept    = push && !queue_full;
    assign addr      = request.address & ADDR_MASK;
    assign word_addr = {addr[ADDR_W-1:1], 1'b0};
    assign acc_shift = {id_acc_reg[15:0], request.read_data[7:0]};
    assign cnt_inc   = id_cnt_reg + 2'd1;
    assign poll_hit  = (request.read_data[7] == exp7_reg);
    assign confirm_st = poll_hit ? ST_OK : ST_FAIL;
    assign mode_bad  = ((request.action <= ACT_BYPASS_ENTER) && bypass_reg)
                    || (((request.action == ACT_BYPASS_PROG)
                        || (request.action == ACT_BYPASS_EXIT)) && !bypass_reg);

    always_comb
    begin
        unique case (request.lanes)
            LANES_LOW:  byp_word = {8'hFF, request.write_data[7:0]};
            LANES_HIGH: byp_word = {request.write_data[15:8], 8'hFF};
            default:    byp_word = request.write_data;
        endcase
    end

    always_comb
    begin
        phase_next     = phase_reg;
        bypass_next    = bypass_reg;
        poll_addr_next = poll_addr_reg;
        exp7_next      = exp7_reg;
        poll_prog_next = poll_prog_reg;
        id_acc_next    = id_acc_reg;
        id_cnt_next    = id_cnt_reg;
        job_push       = '0;
        if (accept)
        begin
            if (request.action == ACT_READ_RETURN)
            begin
                unique case (phase_reg)
                    PH_ID_WAIT:
                    begin
                        id_acc_next    = acc_shift;
                        job_push.valid = 1'b1;
                        if (cnt_inc < 2'd3)
                        begin
                            id_cnt_next  = cnt_inc;
                            job_push.job = make_job(SEQ_READ, id_addr(cnt_inc), D_00,
                                                    ST_OK, 24'h0);
                        end
                        else
                        begin
                            id_cnt_next  = 2'd0;
                            phase_next   = PH_IDLE;
                            job_push.job = make_job(SEQ_RST_DONE, A_ZERO, D_00,
                                                    ST_OK, acc_shift);
                        end
                    end
                    PH_CFI_WAIT:
                    begin
                        phase_next     = PH_IDLE;
                        job_push.valid = 1'b1;
                        job_push.job   = make_job(SEQ_RST_DONE, A_ZERO, D_00, ST_OK,
                                                  {8'h00, request.read_data});
                    end
                    PH_POLL_FIRST:
                    begin
                        phase_next     = PH_POLL;
                        job_push.valid = 1'b1;
                        job_push.job   = make_job(SEQ_READ, poll_addr_reg, D_00,
                                                  ST_OK, 24'h0);
                    end
                    PH_POLL:
                    begin
                        job_push.valid = 1'b1;
                        if (poll_hit)
                        begin
                            phase_next     = PH_IDLE;
                            poll_prog_next = 1'b0;
                            job_push.job   = make_job(poll_prog_reg ? SEQ_RST_DONE
                                                                    : SEQ_DONE,
                                                      A_ZERO, D_00, ST_OK, 24'h0);
                        end
                        else
                        begin
                            if (request.read_data[5])
                                phase_next = PH_POLL_CONFIRM;
                            job_push.job = make_job(SEQ_READ, poll_addr_reg, D_00,
                                                    ST_OK, 24'h0);
                        end
                    end
                    PH_POLL_CONFIRM:
                    begin
                        phase_next     = PH_IDLE;
                        poll_prog_next = 1'b0;
                        job_push.valid = 1'b1;
                        job_push.job   = make_job(poll_prog_reg ? SEQ_RST_DONE : SEQ_DONE,
                                                  A_ZERO, D_00, confirm_st, 24'h0);
                    end
                    default:
                    begin
                        // idle: drop the stray return
                    end
                endcase
            end
            else if (phase_reg == PH_IDLE)
            begin
                job_push.valid = 1'b1;
                if (mode_bad)
                    job_push.job = make_job(SEQ_DONE, A_ZERO, D_00, ST_MODE, 24'h0);
                else
                begin
                    unique case (request.action)
                        ACT_READ_ID:
                        begin
                            id_acc_next  = 24'h0;
                            id_cnt_next  = 2'd0;
                            phase_next   = PH_ID_WAIT;
                            job_push.job = make_job(SEQ_READ_ID, A_ZERO, D_00, ST_OK,
                                                    24'h0);
                        end
                        ACT_CFI:
                        begin
                            phase_next   = PH_CFI_WAIT;
                            job_push.job = make_job(SEQ_CFI, addr, D_00, ST_OK, 24'h0);
                        end
                        ACT_PROGRAM:
                        begin
                            if (!in_window(addr, prot_low_reg, prot_high_reg))
                                job_push.job = make_job(SEQ_DONE, A_ZERO, D_00,
                                                        ST_REFUSED, 24'h0);
                            else
                            begin
                                phase_next     = PH_POLL_FIRST;
                                poll_addr_next = addr;
                                exp7_next      = request.write_data[7];
                                poll_prog_next = 1'b1;
                                job_push.job   = make_job(SEQ_PROGRAM, addr,
                                                          request.write_data, ST_OK, 24'h0);
                            end
                        end
                        ACT_ERASE:
                        begin
                            if (!in_window(addr, prot_low_reg, prot_high_reg))
                                job_push.job = make_job(SEQ_DONE, A_ZERO, D_00,
                                                        ST_REFUSED, 24'h0);
                            else
                            begin
                                phase_next     = PH_POLL_FIRST;
                                poll_addr_next = addr;
                                exp7_next      = 1'b1;
                                poll_prog_next = 1'b0;
                                job_push.job   = make_job(SEQ_ERASE, addr, D_00, ST_OK,
                                                          24'h0);
                            end
                        end
                        ACT_BYPASS_ENTER:
                        begin
                            bypass_next  = 1'b1;
                            job_push.job = make_job(SEQ_BYP_ENTER, A_ZERO, D_00, ST_OK,
                                                    24'h0);
                        end
                        ACT_BYPASS_PROG:
                        begin
                            if (!in_window(word_addr, prot_low_reg, prot_high_reg))
                                job_push.job = make_job(SEQ_DONE, A_ZERO, D_00,
                                                        ST_REFUSED, 24'h0);
                            else
                            begin
                                phase_next     = PH_POLL_FIRST;
                                poll_addr_next = word_addr;
                                exp7_next      = byp_word[7];
                                poll_prog_next = 1'b0;
                                job_push.job   = make_job(SEQ_BYP_PROG, word_addr,
                                                          byp_word, ST_OK, 24'h0);
                            end
                        end
                        default:
                        begin
                            bypass_next  = 1'b0;
                            job_push.job = make_job(SEQ_BYP_EXIT, A_ZERO, D_00, ST_OK,
                                                    24'h0);
                        end
                    endcase
                end
            end
            else
            begin
                // busy: drop the request
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prot_low_reg  <= PROTECT_LOW_RST;
            prot_high_reg <= PROTECT_HIGH_RST;
            phase_reg     <= PH_IDLE;
            bypass_reg    <= 1'b0;
            poll_addr_reg <= '0;
            exp7_reg      <= 1'b0;
            poll_prog_reg <= 1'b0;
            id_acc_reg    <= '0;
            id_cnt_reg    <= '0;
        end
        else
        begin
            if (cfg_valid && (cfg_index == REG_PROTECT_LOW))
                prot_low_reg <= cfg_data;
            if (cfg_valid && (cfg_index == REG_PROTECT_HIGH))
                prot_high_reg <= cfg_data;
            phase_reg     <= phase_next;
            bypass_reg    <= bypass_next;
            poll_addr_reg <= poll_addr_next;
            exp7_reg      <= exp7_next;
            poll_prog_reg <= poll_prog_next;
            id_acc_reg    <= id_acc_next;
            id_cnt_reg    <= id_cnt_next;
        end
    end

endmodule

[hw/rtl/nfcs_job_queue.sv]
module nfcs_job_queue
    import nfcs_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  job_push_t job_push,
    output logic      full,
    input  logic      pop,
    output logic      empty,
    output job_t      head
);

    job_t              entries_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [QPTR_W:0]   count_reg, count_next;
    logic              do_push, do_pop;

    assign full    = (count_reg == (QPTR_W+1)'(QUEUE_DEPTH));
    assign empty   = (count_reg == '0);
    assign do_push = job_push.valid && !full;
    assign do_pop  = pop && !empty;
    assign head    = entries_reg[rd_ptr_reg];

    always_comb
    begin
        count_next = count_reg;
        if (do_push && !do_pop)
            count_next = count_reg + (QPTR_W+1)'(1);
        else if (do_pop && !do_push)
            count_next = count_reg - (QPTR_W+1)'(1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_push)
                wr_ptr_reg <= wr_ptr_reg + QPTR_W'(1);
            if (do_pop)
                rd_ptr_reg <= rd_ptr_reg + QPTR_W'(1);
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
            entries_reg[wr_ptr_reg] <= job_push.job;
    end

endmodule

[hw/rtl/nfcs_back.sv]
module nfcs_back
    import nfcs_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    queue_empty,
    input  job_t    head,
    output logic    queue_pop,
    output logic    empty,
    input  logic    pop,
    output result_t result
);

    logic [2:0] step_reg;
    logic       out_valid_reg;
    result_t    result_reg;
    result_t    step_item;
    logic       load;

    assign step_item = gen_step(head, step_reg);
    // advance when the output slot is free or being drained this cycle
    assign load      = !queue_empty && (!out_valid_reg || pop);
    assign queue_pop = load && step_item.last;
    assign empty     = !out_valid_reg;
    assign result    = result_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (load)
                step_reg <= step_item.last ? 3'd0 : step_reg + 3'd1;
            if (load)
                out_valid_reg <= 1'b1;
            else if (pop)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
            result_reg <= step_item;
    end

endmodule

[hw/rtl/nor_flash_command_sequencer.sv]
// NOR flash command sequencer.
// Request channel (push/full): a transaction is taken at a clock edge with push high and
// full low. Actions cover read ID, CFI query, program, sector erase, unlock bypass
// enter/program/exit, and read return, which hands back the data of the last bus read.
// Result channel (empty/pop): each result is one flash bus cycle (write or read) or an
// operation completion with status and ID/CFI value; last marks the final result that a
// request caused. A request may cause up to seven results, a read return up to two.
// Configuration channel (cfg_valid/cfg_ready): cfg_ready is always high; index 0 sets
// the lowest writable byte address, index 1 the first address above the window.
// An accepted request's job is written into the job queue at its acceptance edge; the
// back end then registers results into the output register, one result per clock
// while the output slot is free or being drained. The front end takes a new transaction
// every cycle while the four-entry job queue has room; full rises only when it has none.
// A stalled receiver (pop low) holds the current result; the back end then stops and
// the job queue fills behind it.
// Reset: window returns to 0x1A0000..0x200000, bypass mode off, sequencer idle,
// queue and output empty.
module nor_flash_command_sequencer
    import nfcs_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 push,
    output logic                 full,
    input  request_t             request,
    output logic                 empty,
    input  logic                 pop,
    output result_t              result,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [PROT_W-1:0]    cfg_data
);

    job_push_t job_push;
    job_t      head;
    logic      queue_full, queue_empty, queue_pop;

    // register writes are always taken
    assign cfg_ready = 1'b1;
    assign full      = queue_full;

    // classify transactions, track mode and polling state
    nfcs_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .request    (request),
        .queue_full (queue_full),
        .cfg_valid  (cfg_valid && cfg_ready),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .job_push   (job_push)
    );

    // hold decoded jobs so front and back stall independently
    nfcs_job_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .job_push (job_push),
        .full     (queue_full),
        .pop      (queue_pop),
        .empty    (queue_empty),
        .head     (head)
    );

    // expand each job into bus cycles and completions, one per clock while the output is free or drained
    nfcs_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .queue_empty (queue_empty),
        .head        (head),
        .queue_pop   (queue_pop),
        .empty       (empty),
        .pop         (pop),
        .result      (result)
    );

endmodule

[hw/rtl/nfcs_checker.sv]
module nfcs_checker
    import nfcs_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    empty,
    input  logic    pop,
    input  result_t result
);

    // a waiting result holds until taken
    assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && !pop) |=> (!empty && $stable(result)))
        else $error("result changed while stalled");

    // a completion carries no bus cycle and closes the request
    assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && result.op_done) |->
            (!result.bus_write && !result.bus_read && result.last))
        else $error("completion with bus cycle or not last");

    // never a read and a write in one result
    assert property (@(posedge clk) disable iff (!rst_n)
        !empty |-> !(result.bus_write && result.bus_read))
        else $error("read and write in one result");

    // status is only reported on a completion
    assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && !result.op_done) |-> (result.op_status == ST_OK))
        else $error("status without completion");

    // reset drains the output
    assert property (@(posedge clk) !rst_n |=> empty)
        else $error("result pending during reset");

endmodule

bind nor_flash_command_sequencer nfcs_checker u_checker (.*);
